// ===== design/sls_pkg.sv =====
`timescale 1ns / 1ps

package sls_pkg;

	localparam int NUM_SLOTS_DEF   = 256;
	localparam int SLOT_BYTES_DEF  = 16;
	localparam int QUEUE_DEPTH_DEF = 32;

	// Pending operation entry: kind in the top bits, parameter below.
	localparam int KIND_W  = 3;
	localparam int PARAM_W = 24;
	localparam int ENTRY_W = KIND_W + PARAM_W;

	localparam logic [2:0] OP_LINK  = 3'd0;
	localparam logic [2:0] OP_OPEN  = 3'd1;
	localparam logic [2:0] OP_CLOSE = 3'd2;
	localparam logic [2:0] OP_ACK   = 3'd3;
	localparam logic [2:0] OP_SEND  = 3'd4;
	localparam logic [2:0] OP_READ  = 3'd5;

	localparam logic [1:0] OUT_DONE    = 2'd0;
	localparam logic [1:0] OUT_REFUSED = 2'd1;
	localparam logic [1:0] OUT_EMPTY   = 2'd2;

	localparam logic [KIND_W-1:0] KIND_OPEN      = 3'd0;
	localparam logic [KIND_W-1:0] KIND_OPEN_CONT = 3'd1;
	localparam logic [KIND_W-1:0] KIND_CLOSE     = 3'd2;
	localparam logic [KIND_W-1:0] KIND_ACK       = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PONG      = 3'd4;

	localparam logic [7:0] SYNC_OUT      = 8'hA5;
	localparam logic [7:0] SYNC_IN       = 8'hA6;
	localparam logic [7:0] CMD_OPEN_TX   = 8'h20;
	localparam logic [7:0] CMD_CLOSE_TX  = 8'h21;
	localparam logic [7:0] CMD_ACK_TX    = 8'h22;
	localparam logic [7:0] CMD_PONG_TX   = 8'h52;
	localparam logic [7:0] CMD_CONNECT   = 8'h30;
	localparam logic [7:0] CMD_DISCONN   = 8'h31;
	localparam logic [7:0] CMD_SLOT_DATA = 8'h40;
	localparam logic [7:0] CMD_PING      = 8'h51;
	localparam logic [7:0] LEN_OPEN      = 8'h04;
	localparam logic [7:0] LEN_SHORT     = 8'h01;
	localparam logic [7:0] LEN_NONE      = 8'h00;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RX_CMD,
		S_SLOT_WR,
		S_SCAN,
		S_TX,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic latch;
		logic rx_step;
		logic run_simple;
		logic wr_step;
		logic scan_step;
		logic pop;
		logic read_issue;
		logic finish;
		logic tx_emit;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       empty;
		logic       slot_cmd;
		logic       wr_last;
		logic       scan_done;
		logic       out_free;
		logic       tx_last;
	} sts_t;

endpackage

// ===== design/slot_link_servicer.sv =====
// A request is latched, decoded and its single result loaded once the output is free; a link
// byte first steps the deframer; one completing a slot data frame writes SLOT_BYTES bytes.
// An open walks the open flags one slot per cycle, over at most NUM_SLOTS slots.
// A send pops the stack, then emits one frame byte per cycle (3 to 7) while output is free.
// One request is in work at a time; the next is taken the cycle after its last result loads.
// Reset is asynchronous and active low; flags, marks and slot data read as zero at once.
`timescale 1ns / 1ps

module slot_link_servicer #(
	parameter int NUM_SLOTS   = sls_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_BYTES  = sls_pkg::SLOT_BYTES_DEF,
	parameter int QUEUE_DEPTH = sls_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] data_id,
	input  logic        continuous,
	input  logic        persistent,
	input  logic [7:0]  slot,
	input  logic [3:0]  byte_index,
	input  logic        clear_dirty,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  outcome,
	output logic [7:0]  slot_id,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        last,
	output logic [7:0]  read_data,
	output logic        was_dirty,
	output logic        slot_is_open,
	output logic        slot_is_connected
);

	import sls_pkg::*;

	// The controller sequences each request; the datapath holds the slot table,
	// the deframer, the pending operation stack and the output register.
	cmd_t cmd;
	sts_t sts;

	sls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Slot data rows carry a valid bit each, so a row never written reads as zero
	// without a clearing pass over the data memory.
	sls_dp #(
		.NUM_SLOTS   (NUM_SLOTS),
		.SLOT_BYTES  (SLOT_BYTES),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.op                (op),
		.rx_byte           (rx_byte),
		.data_id           (data_id),
		.continuous        (continuous),
		.persistent        (persistent),
		.slot              (slot),
		.byte_index        (byte_index),
		.clear_dirty       (clear_dirty),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.outcome           (outcome),
		.slot_id           (slot_id),
		.tx_valid          (tx_valid),
		.tx_byte           (tx_byte),
		.last              (last),
		.read_data         (read_data),
		.was_dirty         (was_dirty),
		.slot_is_open      (slot_is_open),
		.slot_is_connected (slot_is_connected)
	);

`ifndef SYNTHESIS
	// The controller never issues two datapath commands in one cycle.
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.latch, cmd.rx_step, cmd.run_simple, cmd.wr_step, cmd.scan_step,
			cmd.pop, cmd.read_issue, cmd.finish, cmd.tx_emit}))
		else $error("more than one datapath command in a cycle");

	// A request is never taken while the previous one is still in work.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted back to back");

	// Frame bytes always report success.
	a_tx_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && tx_valid) |-> (outcome == OUT_DONE))
		else $error("frame byte with a failure outcome");

	// Every request that is not a frame yields exactly one result.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !tx_valid) |-> last)
		else $error("non-frame result without last");
`endif

endmodule

// ===== design/sls_ram.sv =====
`timescale 1ns / 1ps

module sls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/sls_ctrl.sv =====
`timescale 1ns / 1ps

module sls_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sls_pkg::sts_t sts,
	output sls_pkg::cmd_t cmd
);

	import sls_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_LINK: begin
						cmd.rx_step = 1'b1;
						state_d     = S_RX_CMD;
					end
					OP_OPEN: begin
						state_d = sts.full ? S_RESULT : S_SCAN;
					end
					OP_SEND: begin
						if (sts.empty) begin
							state_d = S_RESULT;
						end else begin
							cmd.pop = 1'b1;
							state_d = S_TX;
						end
					end
					OP_READ: begin
						cmd.read_issue = 1'b1;
						state_d        = S_RESULT;
					end
					default: begin
						state_d = S_RESULT;
					end
				endcase
			end
			S_RX_CMD: begin
				if (sts.slot_cmd) begin
					state_d = S_SLOT_WR;
				end else begin
					cmd.run_simple = 1'b1;
					state_d        = S_RESULT;
				end
			end
			S_SLOT_WR: begin
				cmd.wr_step = 1'b1;
				if (sts.wr_last) begin
					state_d = S_RESULT;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) begin
					state_d = S_RESULT;
				end
			end
			S_TX: begin
				if (sts.out_free) begin
					cmd.tx_emit = 1'b1;
					if (sts.tx_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== design/sls_dp.sv =====
`timescale 1ns / 1ps

module sls_dp #(
	parameter int NUM_SLOTS   = sls_pkg::NUM_SLOTS_DEF,
	parameter int SLOT_BYTES  = sls_pkg::SLOT_BYTES_DEF,
	parameter int QUEUE_DEPTH = sls_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sls_pkg::cmd_t cmd,
	output sls_pkg::sts_t sts,
	input  logic [2:0]    op,
	input  logic [7:0]    rx_byte,
	input  logic [15:0]   data_id,
	input  logic          continuous,
	input  logic          persistent,
	input  logic [7:0]    slot,
	input  logic [3:0]    byte_index,
	input  logic          clear_dirty,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [1:0]    outcome,
	output logic [7:0]    slot_id,
	output logic          tx_valid,
	output logic [7:0]    tx_byte,
	output logic          last,
	output logic [7:0]    read_data,
	output logic          was_dirty,
	output logic          slot_is_open,
	output logic          slot_is_connected
);

	import sls_pkg::*;

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int BYTE_W = $clog2(SLOT_BYTES);
	localparam int KEEP   = SLOT_BYTES + 1;
	localparam int PAY_W  = $clog2(KEEP);
	localparam int SD_DEP = NUM_SLOTS * SLOT_BYTES;
	localparam int SD_AW  = $clog2(SD_DEP);
	localparam int QA_W   = $clog2(QUEUE_DEPTH);
	localparam int DEP_W  = $clog2(QUEUE_DEPTH + 1);

	typedef logic [255:0][SLOT_W-1:0] slot_map_t;
	typedef logic [15:0][BYTE_W-1:0]  byte_map_t;

	function automatic slot_map_t build_slot_map();
		slot_map_t m;
		for (int i = 0; i < 256; i++) begin
			m[i] = SLOT_W'(i % NUM_SLOTS);
		end
		return m;
	endfunction

	function automatic byte_map_t build_byte_map();
		byte_map_t m;
		for (int i = 0; i < 16; i++) begin
			m[i] = BYTE_W'(i % SLOT_BYTES);
		end
		return m;
	endfunction

	localparam slot_map_t SLOT_MAP = build_slot_map();
	localparam byte_map_t BYTE_MAP = build_byte_map();

	// Latched request.
	logic [2:0]        op_q;
	logic [7:0]        byte_q;
	logic [15:0]       id_q;
	logic              cont_q;
	logic              pers_q;
	logic [SLOT_W-1:0] s_q;
	logic [BYTE_W-1:0] bi_q;
	logic              clean_q;

	// Deframer and slot table.
	logic              in_pay_q;
	logic [7:0]        pos_q;
	logic [7:0]        hdr_q [3];
	logic [7:0]        pay_q [KEEP];
	logic              run_q;
	logic [BYTE_W-1:0] wr_cnt_q;
	logic [SLOT_W-1:0] idx_q;
	logic              found_q;
	logic [2:0]        tx_cnt_q;
	logic [DEP_W-1:0]  depth_q;
	logic [NUM_SLOTS-1:0] open_q, conn_q, dirty_q, dvalid_q;

	// Output register.
	logic       out_valid_q;
	logic [1:0] outcome_q;
	logic [7:0] slot_id_q, tx_byte_q, read_data_q;
	logic       tx_valid_q, last_q, was_dirty_q, open_out_q, conn_out_q;

	logic [SLOT_W-1:0]  ps;
	logic               sync_ok, full, empty, cur_open, cur_conn;
	logic               scan_hit, scan_last, open_ok, close_ok, ack_ok;
	logic [8:0]         pos_nxt;
	logic [7:0]         copy_len, wr_byte;
	logic               push_en;
	logic [ENTRY_W-1:0] push_entry;
	logic [SD_AW-1:0]   sd_waddr, sd_raddr;
	logic [7:0]         sd_rdata;
	logic [DEP_W-1:0]   depth_m1;
	logic [ENTRY_W-1:0] stk_rdata;
	logic [KIND_W-1:0]  kind;
	logic [PARAM_W-1:0] param;
	logic               kind_open, kind_short;
	logic [2:0]         tx_n_m1;
	logic [7:0]         tx_b;
	logic               load;
	logic [1:0]         res_outcome;
	logic [7:0]         res_sid, res_rd;
	logic               res_dirty, res_open, res_conn;

	assign ps        = SLOT_MAP[pay_q[0]];
	assign sync_ok   = (hdr_q[0] == SYNC_IN);
	assign full      = (depth_q == DEP_W'(QUEUE_DEPTH));
	assign empty     = (depth_q == '0);
	assign cur_open  = open_q[s_q];
	assign cur_conn  = conn_q[s_q];
	assign scan_hit  = !open_q[idx_q];
	assign scan_last = pers_q ? (idx_q == '0) : (idx_q == SLOT_W'(NUM_SLOTS - 1));
	assign open_ok   = found_q && !full;
	assign close_ok  = cur_open && !full;
	assign ack_ok    = cur_open && cur_conn && !full;
	assign pos_nxt   = {1'b0, pos_q} + 9'd1;
	assign copy_len  = hdr_q[1] - 8'd1;
	assign wr_byte   = (8'(wr_cnt_q) < copy_len) ? pay_q[PAY_W'(wr_cnt_q) + PAY_W'(1)] : 8'd0;
	assign depth_m1  = depth_q - DEP_W'(1);
	assign load      = cmd.finish || cmd.tx_emit;

	always_comb begin
		push_en    = 1'b0;
		push_entry = '0;
		if (cmd.run_simple && run_q && sync_ok && hdr_q[2] == CMD_PING && !full) begin
			push_en    = 1'b1;
			push_entry = {KIND_PONG, PARAM_W'(0)};
		end
		if (cmd.finish) begin
			case (op_q)
				OP_OPEN: begin
					push_en    = open_ok;
					push_entry = {cont_q ? KIND_OPEN_CONT : KIND_OPEN, id_q, 8'(idx_q)};
				end
				OP_CLOSE: begin
					push_en    = close_ok;
					push_entry = {KIND_CLOSE, PARAM_W'(s_q)};
				end
				OP_ACK: begin
					push_en    = ack_ok;
					push_entry = {KIND_ACK, PARAM_W'(s_q)};
				end
				default: begin
					push_en = push_en;
				end
			endcase
		end
	end

	assign sd_waddr = SD_AW'(ps) * SD_AW'(SLOT_BYTES) + SD_AW'(wr_cnt_q);
	assign sd_raddr = SD_AW'(s_q) * SD_AW'(SLOT_BYTES) + SD_AW'(bi_q);

	sls_ram #(.WIDTH(8), .DEPTH(SD_DEP)) u_slot_ram (
		.clk   (clk),
		.we    (cmd.wr_step),
		.waddr (sd_waddr),
		.wdata (wr_byte),
		.re    (cmd.read_issue),
		.raddr (sd_raddr),
		.rdata (sd_rdata)
	);

	sls_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_stack_ram (
		.clk   (clk),
		.we    (push_en),
		.waddr (depth_q[QA_W-1:0]),
		.wdata (push_entry),
		.re    (cmd.pop),
		.raddr (depth_m1[QA_W-1:0]),
		.rdata (stk_rdata)
	);

	// Frame bytes of the popped operation.
	assign kind       = stk_rdata[ENTRY_W-1:PARAM_W];
	assign param      = stk_rdata[PARAM_W-1:0];
	assign kind_open  = (kind == KIND_OPEN) || (kind == KIND_OPEN_CONT);
	assign kind_short = (kind == KIND_CLOSE) || (kind == KIND_ACK);
	assign tx_n_m1    = kind_open ? 3'd6 : (kind_short ? 3'd3 : 3'd2);

	always_comb begin
		case (tx_cnt_q)
			3'd0: tx_b = SYNC_OUT;
			3'd1: tx_b = kind_open ? LEN_OPEN : (kind_short ? LEN_SHORT : LEN_NONE);
			3'd2: begin
				if (kind_open) begin
					tx_b = CMD_OPEN_TX;
				end else if (kind == KIND_CLOSE) begin
					tx_b = CMD_CLOSE_TX;
				end else if (kind == KIND_ACK) begin
					tx_b = CMD_ACK_TX;
				end else begin
					tx_b = CMD_PONG_TX;
				end
			end
			3'd3: tx_b = kind_open ? {7'd0, kind == KIND_OPEN_CONT} : param[7:0];
			3'd4: tx_b = param[7:0];
			3'd5: tx_b = param[15:8];
			default: tx_b = param[23:16];
		endcase
	end

	always_comb begin
		res_outcome = OUT_DONE;
		res_sid     = 8'd0;
		res_rd      = 8'd0;
		res_dirty   = 1'b0;
		res_open    = 1'b0;
		res_conn    = 1'b0;
		case (op_q)
			OP_LINK: begin
				res_outcome = OUT_DONE;
			end
			OP_OPEN: begin
				res_outcome = open_ok ? OUT_DONE : OUT_REFUSED;
				res_sid     = open_ok ? 8'(idx_q) : 8'd0;
				res_open    = open_ok;
			end
			OP_CLOSE: begin
				res_outcome = close_ok ? OUT_DONE : OUT_REFUSED;
				res_open    = cur_open;
				res_conn    = cur_conn;
			end
			OP_ACK: begin
				res_outcome = ack_ok ? OUT_DONE : OUT_REFUSED;
				res_open    = cur_open;
				res_conn    = cur_conn;
			end
			OP_SEND: begin
				res_outcome = OUT_EMPTY;
			end
			OP_READ: begin
				res_rd    = dvalid_q[s_q] ? sd_rdata : 8'd0;
				res_dirty = dirty_q[s_q];
				res_open  = cur_open;
				res_conn  = cur_conn;
			end
			default: begin
				res_outcome = OUT_REFUSED;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= op;
			byte_q  <= rx_byte;
			id_q    <= data_id;
			cont_q  <= continuous;
			pers_q  <= persistent;
			s_q     <= SLOT_MAP[slot];
			bi_q    <= BYTE_MAP[byte_index];
			clean_q <= clear_dirty;
		end
		if (cmd.finish) begin
			outcome_q   <= res_outcome;
			slot_id_q   <= res_sid;
			tx_valid_q  <= 1'b0;
			tx_byte_q   <= 8'd0;
			last_q      <= 1'b1;
			read_data_q <= res_rd;
			was_dirty_q <= res_dirty;
			open_out_q  <= res_open;
			conn_out_q  <= res_conn;
		end else if (cmd.tx_emit) begin
			outcome_q   <= OUT_DONE;
			slot_id_q   <= 8'd0;
			tx_valid_q  <= 1'b1;
			tx_byte_q   <= tx_b;
			last_q      <= (tx_cnt_q == tx_n_m1);
			read_data_q <= 8'd0;
			was_dirty_q <= 1'b0;
			open_out_q  <= 1'b0;
			conn_out_q  <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pay_q    <= 1'b0;
			pos_q       <= 8'd0;
			hdr_q       <= '{default: 8'd0};
			pay_q       <= '{default: 8'd0};
			run_q       <= 1'b0;
			wr_cnt_q    <= '0;
			idx_q       <= '0;
			found_q     <= 1'b0;
			tx_cnt_q    <= 3'd0;
			depth_q     <= '0;
			open_q      <= '0;
			conn_q      <= '0;
			dirty_q     <= '0;
			dvalid_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.latch) begin
				wr_cnt_q <= '0;
				tx_cnt_q <= 3'd0;
				found_q  <= 1'b0;
				idx_q    <= persistent ? SLOT_W'(NUM_SLOTS - 1) : '0;
			end
			if (cmd.rx_step) begin
				run_q <= 1'b0;
				if (!in_pay_q) begin
					hdr_q[pos_q[1:0]] <= byte_q;
					if (pos_q == 8'd2) begin
						pos_q <= 8'd0;
						if (hdr_q[1] == 8'd0) begin
							run_q <= 1'b1;
						end else if (sync_ok) begin
							in_pay_q <= 1'b1;
						end
					end else begin
						pos_q <= pos_nxt[7:0];
					end
				end else begin
					if (pos_q < 8'(KEEP)) begin
						pay_q[pos_q[PAY_W-1:0]] <= byte_q;
					end
					if (pos_nxt >= {1'b0, hdr_q[1]}) begin
						pos_q    <= 8'd0;
						in_pay_q <= 1'b0;
						run_q    <= 1'b1;
					end else begin
						pos_q <= pos_nxt[7:0];
					end
				end
			end
			if (cmd.run_simple && run_q && sync_ok) begin
				case (hdr_q[2])
					CMD_CONNECT: conn_q[ps] <= 1'b1;
					CMD_DISCONN: begin
						open_q[ps] <= 1'b0;
						conn_q[ps] <= 1'b0;
					end
					default: begin
						run_q <= 1'b0;
					end
				endcase
			end
			if (cmd.wr_step) begin
				wr_cnt_q <= wr_cnt_q + BYTE_W'(1);
				if (wr_cnt_q == BYTE_W'(SLOT_BYTES - 1)) begin
					dirty_q[ps]  <= 1'b1;
					dvalid_q[ps] <= 1'b1;
				end
			end
			if (cmd.scan_step) begin
				if (scan_hit) begin
					found_q <= 1'b1;
				end else if (!scan_last) begin
					idx_q <= pers_q ? idx_q - SLOT_W'(1) : idx_q + SLOT_W'(1);
				end
			end
			if (cmd.pop) begin
				depth_q <= depth_m1;
			end else if (push_en) begin
				depth_q <= depth_q + DEP_W'(1);
			end
			if (cmd.tx_emit) begin
				tx_cnt_q <= tx_cnt_q + 3'd1;
			end
			if (cmd.finish) begin
				if (op_q == OP_OPEN && open_ok) begin
					open_q[idx_q] <= 1'b1;
					conn_q[idx_q] <= 1'b0;
				end
				if (op_q == OP_READ && clean_q) begin
					dirty_q[s_q] <= 1'b0;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.op        = op_q;
	assign sts.full      = full;
	assign sts.empty     = empty;
	assign sts.slot_cmd  = run_q && sync_ok && (hdr_q[2] == CMD_SLOT_DATA);
	assign sts.wr_last   = (wr_cnt_q == BYTE_W'(SLOT_BYTES - 1));
	assign sts.scan_done = scan_hit || scan_last;
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.tx_last   = (tx_cnt_q == tx_n_m1);

	assign out_valid         = out_valid_q;
	assign outcome           = outcome_q;
	assign slot_id           = slot_id_q;
	assign tx_valid          = tx_valid_q;
	assign tx_byte           = tx_byte_q;
	assign last              = last_q;
	assign read_data         = read_data_q;
	assign was_dirty         = was_dirty_q;
	assign slot_is_open      = open_out_q;
	assign slot_is_connected = conn_out_q;

endmodule

// ===== tb/slot_link_checker.sv =====
`timescale 1ns / 1ps

module slot_link_checker
	import sls_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] data_id,
	input  logic        continuous,
	input  logic        persistent,
	input  logic [7:0]  slot,
	input  logic [3:0]  byte_index,
	input  logic        clear_dirty,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  outcome,
	input  logic [7:0]  slot_id,
	input  logic        tx_valid,
	input  logic [7:0]  tx_byte,
	input  logic        last,
	input  logic [7:0]  read_data,
	input  logic        was_dirty,
	input  logic        slot_is_open,
	input  logic        slot_is_connected,
	output int          fail_count,
	output int          awaited
);

	typedef struct packed {
		logic [1:0] outcome;
		logic [7:0] slot_id;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       last;
		logic [7:0] read_data;
		logic       was_dirty;
		logic       is_open;
		logic       is_conn;
	} reply_t;

	localparam int NS = NUM_SLOTS_DEF;
	localparam int SB = SLOT_BYTES_DEF;
	localparam int QD = QUEUE_DEPTH_DEF;

	logic [1:0]         flags [NS];
	logic               dirty [NS];
	logic [7:0]         sdata [NS][SB];
	logic [ENTRY_W-1:0] stack [QD];
	int                 depth;
	logic               in_pay;
	int                 rxpos;
	logic [7:0]         hdr [3];
	logic [7:0]         pay [SB+1];
	reply_t             replies [$];

	assign awaited = replies.size();

	function automatic reply_t blank();
		reply_t r;
		r = '0;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic bit push_pending(logic [KIND_W-1:0] k, logic [PARAM_W-1:0] p);
		if (depth >= QD) return 0;
		stack[depth] = {k, p};
		depth++;
		return 1;
	endfunction

	task automatic reset_model();
		for (int i = 0; i < NS; i++) begin
			flags[i] = '0;
			dirty[i] = '0;
			for (int j = 0; j < SB; j++) sdata[i][j] = '0;
		end
		for (int i = 0; i < 3; i++) hdr[i] = '0;
		for (int i = 0; i <= SB; i++) pay[i] = '0;
		depth = 0;
		in_pay = 0;
		rxpos = 0;
		replies.delete();
	endtask

	task automatic apply_frame();
		int s;
		int n;
		s = pay[0];
		if (hdr[0] != SYNC_IN) return;
		case (hdr[2])
			CMD_CONNECT: flags[s][1] = 1'b1;
			CMD_DISCONN: flags[s] = 2'b00;
			CMD_SLOT_DATA: begin
				n = (hdr[1] - 8'd1) & 8'hFF;
				if (n > SB) n = SB;
				for (int i = 0; i < SB; i++) sdata[s][i] = (i < n) ? pay[i+1] : 8'h00;
				dirty[s] = 1'b1;
			end
			CMD_PING: void'(push_pending(KIND_PONG, '0));
			default: ;
		endcase
	endtask

	task automatic deframe(logic [7:0] b);
		if (!in_pay) begin
			if (rxpos < 3) hdr[rxpos] = b;
			rxpos++;
			if (rxpos >= 3) begin
				rxpos = 0;
				if (hdr[1] == 0) apply_frame();
				else if (hdr[0] == SYNC_IN) in_pay = 1'b1;
			end
		end else begin
			if (rxpos < SB + 1) pay[rxpos] = b;
			rxpos++;
			if (rxpos >= hdr[1]) begin
				rxpos = 0;
				in_pay = 1'b0;
				apply_frame();
			end
		end
	endtask

	task automatic predict_request();
		reply_t r;
		int s;
		int found;
		logic [ENTRY_W-1:0] e;
		logic [7:0] fr [7];
		int n;
		r = blank();
		s = slot;
		case (op)
			OP_LINK: begin
				deframe(rx_byte);
				replies.push_back(r);
			end
			OP_OPEN: begin
				found = -1;
				if (persistent) begin
					for (int i = NS - 1; i >= 0; i--)
						if (!flags[i][0]) begin found = i; break; end
				end else begin
					for (int i = 0; i < NS; i++)
						if (!flags[i][0]) begin found = i; break; end
				end
				if (found < 0 || !push_pending(continuous ? KIND_OPEN_CONT : KIND_OPEN,
						{data_id, found[7:0]})) begin
					r.outcome = OUT_REFUSED;
				end else begin
					flags[found] = 2'b01;
					r.slot_id = found[7:0];
					r.is_open = 1'b1;
				end
				replies.push_back(r);
			end
			OP_CLOSE, OP_ACK: begin
				if (op == OP_CLOSE ? flags[s][0] : flags[s] == 2'b11) begin
					if (!push_pending(op == OP_CLOSE ? KIND_CLOSE : KIND_ACK, PARAM_W'(s)))
						r.outcome = OUT_REFUSED;
				end else begin
					r.outcome = OUT_REFUSED;
				end
				r.is_open = flags[s][0];
				r.is_conn = flags[s][1];
				replies.push_back(r);
			end
			OP_SEND: begin
				if (depth == 0) begin
					r.outcome = OUT_EMPTY;
					replies.push_back(r);
				end else begin
					depth--;
					e = stack[depth];
					fr[0] = SYNC_OUT;
					if (e[26:24] == KIND_OPEN || e[26:24] == KIND_OPEN_CONT) begin
						fr[1] = LEN_OPEN;
						fr[2] = CMD_OPEN_TX;
						fr[3] = (e[26:24] == KIND_OPEN_CONT) ? 8'd1 : 8'd0;
						fr[4] = e[7:0];
						fr[5] = e[15:8];
						fr[6] = e[23:16];
						n = 7;
					end else if (e[26:24] == KIND_CLOSE || e[26:24] == KIND_ACK) begin
						fr[1] = LEN_SHORT;
						fr[2] = (e[26:24] == KIND_CLOSE) ? CMD_CLOSE_TX : CMD_ACK_TX;
						fr[3] = e[7:0];
						n = 4;
					end else begin
						fr[1] = LEN_NONE;
						fr[2] = CMD_PONG_TX;
						n = 3;
					end
					for (int k = 0; k < n; k++) begin
						r = '0;
						r.tx_valid = 1'b1;
						r.tx_byte = fr[k];
						r.last = (k == n - 1);
						replies.push_back(r);
					end
				end
			end
			OP_READ: begin
				r.read_data = sdata[s][byte_index];
				r.was_dirty = dirty[s];
				if (clear_dirty) dirty[s] = 1'b0;
				r.is_open = flags[s][0];
				r.is_conn = flags[s][1];
				replies.push_back(r);
			end
			default: begin
				r.outcome = OUT_REFUSED;
				replies.push_back(r);
			end
		endcase
	endtask

	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (!arst_n) begin
			reset_model();
		end else begin
			if (out_valid && out_ready) begin
				got = {outcome, slot_id, tx_valid, tx_byte, last, read_data, was_dirty,
					slot_is_open, slot_is_connected};
				if (replies.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result %h", got);
				end else begin
					want = replies.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected %p actual %p", want, got);
					end
				end
			end
			if (in_valid && in_ready) predict_request();
		end
	end

endmodule

// ===== tb/tb_slot_link_servicer.sv =====
`timescale 1ns / 1ps

module tb_slot_link_servicer;
	import sls_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [2:0]  op = '0;
	logic [7:0]  rx_byte = '0;
	logic [15:0] data_id = '0;
	logic        continuous = 0;
	logic        persistent = 0;
	logic [7:0]  slot = '0;
	logic [3:0]  byte_index = '0;
	logic        clear_dirty = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [1:0]  outcome;
	logic [7:0]  slot_id;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        last;
	logic [7:0]  read_data;
	logic        was_dirty;
	logic        slot_is_open;
	logic        slot_is_connected;
	int          fail_count;
	int          awaited;

	// A long receiver stall is requested by the stimulus process, which bumps hold_req,
	// and served by the receiver process, which counts it out on its own.
	int          hold_req;
	int          idle_cycles;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	slot_link_servicer u_dut (.*);

	slot_link_checker u_chk (.*);

	// Receiver: a random wait before each result, or a long hold-off when asked for.
	initial begin
		int w;
		int served;
		served = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req != served) begin
				out_ready <= 0;
				repeat (300) @(posedge clk);
				served = hold_req;
			end
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (w > 0) begin
				out_ready <= 0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!(out_valid && out_ready)) @(posedge clk);
		end
	end

	// Watchdog: counts cycles without any accepted request or result; its limit lies well above
	// both an open scan and the long hold-off.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 2000) begin
			$display("slot_link_servicer verification failed");
			$finish;
		end
	end

	// Offer one request, after a random gap when gaps is set, and wait until it is taken.
	task automatic send_request(logic [2:0] o, logic [7:0] b, logic [15:0] id, bit c, bit p,
			logic [7:0] s, logic [3:0] bi, bit mc, bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 6) : 0;
		if (w > 0) begin
			in_valid <= 0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1;
		op <= o;
		rx_byte <= b;
		data_id <= id;
		continuous <= c;
		persistent <= p;
		slot <= s;
		byte_index <= bi;
		clear_dirty <= mc;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic link_byte(logic [7:0] b);
		send_request(OP_LINK, b, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom_range(0, 2) != 0);
	endtask

	// A whole inbound frame: sync, length, command, then the payload.
	task automatic link_frame(logic [7:0] sync, logic [7:0] len, logic [7:0] cmd,
			logic [7:0] target);
		link_byte(sync);
		link_byte(len);
		link_byte(cmd);
		for (int i = 0; i < len; i++) link_byte(i == 0 ? target : 8'($urandom));
	endtask

	task automatic random_request(bit gaps);
		int pick;
		logic [7:0] s;
		pick = $urandom_range(0, 99);
		// Slots are mostly drawn from a small window so that flags collide often.
		s = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
		if (pick < 25) begin
			case ($urandom_range(0, 5))
				0: link_frame(SYNC_IN, 0, CMD_PING, 0);
				1: link_frame(SYNC_IN, 1, CMD_CONNECT, s);
				2: link_frame(SYNC_IN, 1, CMD_DISCONN, s);
				3: link_frame(SYNC_IN, $urandom_range(1, 20), CMD_SLOT_DATA, s);
				4: link_frame(8'($urandom), $urandom_range(0, 3), 8'($urandom), s);
				default: link_byte($urandom);
			endcase
		end else begin
			send_request($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom, s,
				$urandom, $urandom, gaps);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
	endtask

	initial begin
		hold_req = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed part: every operation, field extremes and the frame special cases.
		send_request(OP_SEND, 0, 0, 0, 0, 0, 0, 0, 1);
		send_request(OP_OPEN, 0, 16'hFFFF, 1, 1, 0, 0, 0, 1);
		send_request(OP_OPEN, 0, 16'h0000, 0, 0, 0, 0, 0, 1);
		send_request(OP_ACK, 0, 0, 0, 0, 8'hFF, 0, 0, 1);
		link_frame(SYNC_IN, 1, CMD_CONNECT, 8'hFF);
		send_request(OP_ACK, 0, 0, 0, 0, 8'hFF, 0, 0, 1);
		send_request(OP_CLOSE, 0, 0, 0, 0, 8'h00, 0, 0, 1);
		link_frame(SYNC_IN, 20, CMD_SLOT_DATA, 8'h00);
		send_request(OP_READ, 0, 0, 0, 0, 8'h00, 4'hF, 1, 1);
		send_request(OP_READ, 0, 0, 0, 0, 8'h00, 4'h0, 0, 1);
		link_frame(SYNC_IN, 0, CMD_SLOT_DATA, 0);
		link_frame(8'h5A, 2, CMD_PING, 0);
		link_frame(SYNC_IN, 0, CMD_PING, 0);
		link_frame(SYNC_IN, 1, 8'h77, 0);
		link_frame(SYNC_IN, 1, CMD_DISCONN, 8'hFF);
		send_request(3'd6, 0, 0, 0, 0, 0, 0, 0, 1);
		send_request(3'd7, 8'hFF, 0, 0, 0, 0, 0, 0, 1);
		repeat (6) send_request(OP_SEND, 0, 0, 0, 0, 0, 0, 0, 1);

		// Fill the queue past its depth so full-queue refusals and pings are seen.
		repeat (34) send_request(OP_OPEN, 0, $urandom, $urandom, $urandom, 0, 0, 0, 0);
		link_frame(SYNC_IN, 0, CMD_PING, 0);
		send_request(OP_CLOSE, 0, 0, 0, 0, 8'd1, 0, 0, 0);

		// Long receiver stall while requests keep coming, then a full pause.
		hold_req = hold_req + 1;
		repeat (20) send_request(OP_SEND, 0, 0, 0, 0, 0, 0, 0, 0);
		drain();

		repeat (50) random_request(1);
		drain();
		repeat (40) random_request(0);
		repeat (30) send_request(OP_SEND, 0, 0, 0, 0, 0, 0, 0, 1);
		repeat (40) random_request(1);
		drain();

		repeat (50) @(posedge clk);
		if (fail_count == 0 && awaited == 0)
			$display("slot_link_servicer verification clean");
		else
			$display("slot_link_servicer verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/sls_pkg.sv
design/sls_ram.sv
design/sls_ctrl.sv
design/sls_dp.sv
design/slot_link_servicer.sv
tb/slot_link_checker.sv
tb/tb_slot_link_servicer.sv
